/* design/c3sm_pkg.sv */
// Shared types, constants and mask helpers for the 3x3 selectable-mask convolution.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package c3sm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W    = 8;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_W    = 13;
  localparam int SUM_W    = 13;

  // Divide by 9 as multiply by reciprocal, exact for dividends below 2^15.
  localparam int DIV_MULT_W = 14;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = 14'd14564;
  localparam int DIV_SHIFT  = 17;
  localparam int DIV_IN_W   = 12;
  localparam int PROD_W     = DIV_IN_W + DIV_MULT_W;
  localparam int QUO_W      = PROD_W - DIV_SHIFT;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [1:0] MODE_BOX     = 2'd0;
  localparam logic [1:0] MODE_VSOBEL  = 2'd1;
  localparam logic [1:0] MODE_HSOBEL  = 2'd2;
  localparam logic [1:0] MODE_LAPLACE = 2'd3;

  localparam logic [2:0] WGT_ZERO = 3'd0;
  localparam logic [2:0] WGT_POS1 = 3'd1;
  localparam logic [2:0] WGT_POS2 = 3'd2;
  localparam logic [2:0] WGT_POS8 = 3'd3;
  localparam logic [2:0] WGT_NEG1 = 3'd4;
  localparam logic [2:0] WGT_NEG2 = 3'd5;

  // index 0: older row, 1: newer row, 2: current row
  typedef logic [2:0][PIX_W-1:0] column_t;
  typedef logic [2:0][2:0] col_weights_t;

  typedef struct packed {
    logic [PIX_W-1:0] older;
    logic [PIX_W-1:0] newer;
  } line_pair_t;

  typedef struct packed {
    logic interior;
    logic need1;
    logic need2;
    logic need3;
    logic eoi;
  } flags_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] v1;
    logic [PIX_W-1:0] v2;
    logic [PIX_W-1:0] v3;
    logic             need1;
    logic             need2;
    logic             need3;
    logic             eoi;
  } res_set_t;

  // Mask row a pairs with column offset a-1, mask column b with row offset b-1.
  function automatic logic [2:0] mask_weight(input logic [1:0] mode, input logic [1:0] a,
                                             input logic [1:0] b);
    logic [2:0] w;
    w = WGT_ZERO;
    unique case (mode)
      MODE_BOX: begin
        w = WGT_POS1;
      end
      MODE_VSOBEL: begin
        if (a == 2'd0) w = (b == 2'd1) ? WGT_NEG2 : WGT_NEG1;
        else if (a == 2'd2) w = (b == 2'd1) ? WGT_POS2 : WGT_POS1;
        else w = WGT_ZERO;
      end
      MODE_HSOBEL: begin
        if (b == 2'd0) w = (a == 2'd1) ? WGT_NEG2 : WGT_NEG1;
        else if (b == 2'd2) w = (a == 2'd1) ? WGT_POS2 : WGT_POS1;
        else w = WGT_ZERO;
      end
      MODE_LAPLACE: begin
        w = (a == 2'd1 && b == 2'd1) ? WGT_POS8 : WGT_NEG1;
      end
      default: begin
        w = WGT_ZERO;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [SUM_W-1:0] scale_pixel(input logic [2:0] code,
                                                          input logic [PIX_W-1:0] p);
    logic signed [SUM_W-1:0] v;
    logic signed [SUM_W-1:0] r;
    v = $signed({{(SUM_W-PIX_W){1'b0}}, p});
    case (code)
      WGT_POS1: r = v;
      WGT_POS2: r = v <<< 1;
      WGT_POS8: r = v <<< 3;
      WGT_NEG1: r = -v;
      WGT_NEG2: r = -(v <<< 1);
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/c3sm_line_store.sv */
// Two-row line store: each entry holds the older and newer row pixel of one column.
// Registered read, one write per cycle. Depends on c3sm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c3sm_line_store (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [c3sm_pkg::COL_W-1:0]    rd_addr,
  output c3sm_pkg::line_pair_t          rd_data,
  input  logic                          wr_en,
  input  logic [c3sm_pkg::COL_W-1:0]    wr_addr,
  input  c3sm_pkg::line_pair_t          wr_data
);
  import c3sm_pkg::*;

  line_pair_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* design/c3sm_cell.sv */
// One window cell: holds a three-pixel column, hands it on when the window shifts,
// and forms the mask-weighted sum of its column. Depends on c3sm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c3sm_cell (
  input  logic                               clk,
  input  logic                               shift,
  input  c3sm_pkg::column_t                  col_in,
  input  c3sm_pkg::col_weights_t             weights,
  output c3sm_pkg::column_t                  col_out,
  output logic signed [c3sm_pkg::SUM_W-1:0]  col_sum
);
  import c3sm_pkg::*;

  column_t pixels;

  always_ff @(posedge clk) begin
    if (shift) begin
      pixels <= col_in;
    end
  end

  assign col_out = pixels;

  always_comb begin
    col_sum = scale_pixel(weights[0], pixels[0])
            + scale_pixel(weights[1], pixels[1])
            + scale_pixel(weights[2], pixels[2]);
  end

endmodule

`default_nettype wire

/* design/c3sm_out_stage.sv */
// Output register: holds the up to three results of one item and issues them in order.
// Depends on c3sm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c3sm_out_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load_valid,
  output logic                          load_ready,
  input  c3sm_pkg::res_set_t            res,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [c3sm_pkg::ROW_W-1:0]    out_row,
  output logic [c3sm_pkg::COL_W-1:0]    out_col,
  output logic [c3sm_pkg::PIX_W-1:0]    pixel_value,
  output logic                          last_of_run,
  output logic                          end_of_image
);
  import c3sm_pkg::*;

  res_set_t   held;
  logic [2:0] pend;
  logic       load;
  logic       take;

  assign out_valid  = (pend != 3'd0);
  assign take       = out_valid && out_ready;
  assign load_ready = (pend == 3'd0) || (take && last_of_run);
  assign load       = load_valid && load_ready;

  always_comb begin
    if (pend[0]) begin
      out_row     = held.row - 1'b1;
      out_col     = held.col - 1'b1;
      pixel_value = held.v1;
      last_of_run = !pend[1] && !pend[2];
    end else if (pend[1]) begin
      out_row     = held.row - 1'b1;
      out_col     = held.col;
      pixel_value = held.v2;
      last_of_run = !pend[2];
    end else begin
      out_row     = held.row;
      out_col     = held.col;
      pixel_value = held.v3;
      last_of_run = 1'b1;
    end
    end_of_image = held.eoi && last_of_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 3'd0;
    end else if (load) begin
      pend <= {res.need3, res.need2, res.need1};
    end else if (take) begin
      pend <= pend & (pend - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

`ifndef SYNTHESIS
  a_eoi_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_image |-> last_of_run)
    else $error("end of image flagged on a result that is not last of its item");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    take && !last_of_run |=> out_valid)
    else $error("results of one item broken off");

  a_pend_shrinks: assert property (@(posedge clk) disable iff (rst)
    !load |=> $countones(pend) <= $past($countones(pend)))
    else $error("pending results grew without a load");
`endif

endmodule

`default_nettype wire

/* design/conv3x3_selectable_mask.sv */
// Top level of the streaming 3x3 convolution with selectable mask.
// Depends on c3sm_pkg, c3sm_line_store, c3sm_cell and c3sm_out_stage.
`timescale 1ns / 1ps
`default_nettype none

// Takes one 8-bit grey pixel per cycle in raster order while out_ready is high and
// returns filtered pixels, border pixels unfiltered, tagged with row and column via
// stage 1, the window cells, stage 3 and the output register. An item that causes
// one result or none leaves room for the next item in the very next cycle; one that
// causes two or three holds the input until all are issued, as the single output
// register issues one result per cycle. The window is a chain of three column cells
// fed from a two-row line store with one read and one write per cycle.
// Configuration is to be written with the block idle; the block does not check it.
module conv3x3_selectable_mask (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [c3sm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [c3sm_pkg::PIX_W-1:0]     pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [c3sm_pkg::ROW_W-1:0]     out_row,
  output logic [c3sm_pkg::COL_W-1:0]     out_col,
  output logic [c3sm_pkg::PIX_W-1:0]     pixel_value,
  output logic                           last_of_run,
  output logic                           end_of_image
);
  import c3sm_pkg::*;

  logic [1:0]          mode;
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  logic [ROW_W-1:0]    row_position;
  logic [COL_W-1:0]    col_position;
  logic [ROW_W-1:0]    row_position_next;
  logic [COL_W-1:0]    col_position_next;
  logic [ROW_W-1:0]    cur_row;
  logic [COL_W-1:0]    cur_col;
  flags_t              cur_flags;
  logic                accept;

  logic                s1_valid;
  logic [PIX_W-1:0]    s1_pix;
  logic [ROW_W-1:0]    s1_row;
  logic [COL_W-1:0]    s1_col;
  flags_t              s1_flags;
  logic                s1_free;
  logic                shift;
  line_pair_t          rd_data;
  line_pair_t          wr_data;
  column_t             new_col;

  logic                s2_valid;
  logic [ROW_W-1:0]    s2_row;
  logic [COL_W-1:0]    s2_col;
  flags_t              s2_flags;
  logic                s2_free;
  col_weights_t        wts [3];
  column_t             cell_col [3];
  logic signed [SUM_W-1:0] cell_sum [3];

  logic                s3_valid;
  logic signed [SUM_W-1:0] s3_sum;
  logic [ROW_W-1:0]    s3_row;
  logic [COL_W-1:0]    s3_col;
  flags_t              s3_flags;
  logic [PIX_W-1:0]    s3_v1;
  logic [PIX_W-1:0]    s3_v2;
  logic [PIX_W-1:0]    s3_v3;
  logic                s3_free;
  logic [DIV_IN_W-1:0] s_mag;
  logic [PROD_W-1:0]   prod;
  logic [QUO_W-1:0]    quo;
  logic [PIX_W-1:0]    filt;
  res_set_t            res;
  logic                s4_ready;
  logic                res_ready;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_BOX;
      image_width  <= WIDTH_W'(512);
      image_height <= HEIGHT_W'(512);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:   mode         <= cfg_data[1:0];
        REG_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (image_width < WIDTH_W'(3)) w_eff = WIDTH_W'(3);
    else if (image_width > WIDTH_W'(MAX_WIDTH)) w_eff = WIDTH_W'(MAX_WIDTH);
    else w_eff = image_width;
    if (image_height < HEIGHT_W'(3)) h_eff = HEIGHT_W'(3);
    else if (image_height > HEIGHT_W'(MAX_HEIGHT)) h_eff = HEIGHT_W'(MAX_HEIGHT);
    else h_eff = image_height;
  end

  // position of the item at the input
  always_comb begin
    logic                col_wrap;
    logic [HEIGHT_W-1:0] row_tmp;
    logic [WIDTH_W-1:0]  col_inc;
    logic [HEIGHT_W-1:0] row_inc;
    col_wrap = {1'b0, col_position} >= w_eff;
    row_tmp  = {1'b0, row_position} + (col_wrap ? HEIGHT_W'(1) : HEIGHT_W'(0));
    cur_row  = (row_tmp >= h_eff) ? '0 : row_tmp[ROW_W-1:0];
    cur_col  = col_wrap ? '0 : col_position;

    col_inc = {1'b0, cur_col} + WIDTH_W'(1);
    row_inc = {1'b0, cur_row} + HEIGHT_W'(1);
    if (col_inc >= w_eff) begin
      col_position_next = '0;
      row_position_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_position_next = col_inc[COL_W-1:0];
      row_position_next = cur_row;
    end

    cur_flags.need1    = (cur_row != '0) && (cur_col != '0);
    cur_flags.interior = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
    cur_flags.need2    = (cur_row != '0) && ({1'b0, cur_col} == w_eff - WIDTH_W'(1));
    cur_flags.need3    = ({1'b0, cur_row} == h_eff - HEIGHT_W'(1));
    cur_flags.eoi      = cur_flags.need3 && ({1'b0, cur_col} == w_eff - WIDTH_W'(1));
  end

  assign s4_ready = s3_free;
  assign s3_free  = !s3_valid || res_ready;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position <= '0;
      col_position <= '0;
    end else if (accept) begin
      row_position <= row_position_next;
      col_position <= col_position_next;
    end
  end

  // stage 1: line store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= pixel;
      s1_row   <= cur_row;
      s1_col   <= cur_col;
      s1_flags <= cur_flags;
    end
  end

  assign shift         = s1_valid && s2_free;
  assign wr_data.older = rd_data.newer;
  assign wr_data.newer = s1_pix;
  assign new_col       = {s1_pix, rd_data.newer, rd_data.older};

  c3sm_line_store u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (cur_col),
    .rd_data (rd_data),
    .wr_en   (shift),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  // stage 2: window cells, newest column in cell 0
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        wts[a][b] = mask_weight(mode, 2'(a), 2'(b));
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_cell
    column_t cin;
    if (k == 0) begin : g_head
      assign cin = new_col;
    end else begin : g_link
      assign cin = cell_col[k-1];
    end
    c3sm_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .col_in  (cin),
      .weights (wts[2-k]),
      .col_out (cell_col[k]),
      .col_sum (cell_sum[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      s2_row   <= s1_row;
      s2_col   <= s1_col;
      s2_flags <= s1_flags;
    end
  end

  // stage 3: sum registered, divide and clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s3_free) begin
      s3_sum   <= cell_sum[0] + cell_sum[1] + cell_sum[2];
      s3_row   <= s2_row;
      s3_col   <= s2_col;
      s3_flags <= s2_flags;
      s3_v1    <= cell_col[1][1];
      s3_v2    <= cell_col[0][1];
      s3_v3    <= cell_col[0][2];
    end
  end

  always_comb begin
    s_mag = s3_sum[DIV_IN_W-1:0];
    prod  = PROD_W'(s_mag) * PROD_W'(DIV_MULT);
    quo   = prod[DIV_SHIFT +: QUO_W];
    if (s3_sum < 0) filt = '0;
    else if (quo > QUO_W'(255)) filt = 8'd255;
    else filt = quo[PIX_W-1:0];

    res.row   = s3_row;
    res.col   = s3_col;
    res.v1    = s3_flags.interior ? filt : s3_v1;
    res.v2    = s3_v2;
    res.v3    = s3_v3;
    res.need1 = s3_flags.need1;
    res.need2 = s3_flags.need2;
    res.need3 = s3_flags.need3;
    res.eoi   = s3_flags.eoi;
  end

  // stage 4: result issue
  c3sm_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (s3_valid && s4_ready),
    .load_ready   (res_ready),
    .res          (res),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_row      (out_row),
    .out_col      (out_col),
    .pixel_value  (pixel_value),
    .last_of_run  (last_of_run),
    .end_of_image (end_of_image)
  );

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item did not enter the pipeline");

  a_full_holds_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_free |-> !in_ready)
    else $error("input taken while the pipeline is blocked");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(pixel_value))
    else $error("waiting result changed before it was taken");
`endif

endmodule

`default_nettype wire
